// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hdl/lhps_pkg.sv =====
// ----------------------------------------------------------------------------
// lhps_pkg
// Types and constants of the oscillator harmonic plan selector.
// ----------------------------------------------------------------------------
package lhps_pkg;

  // working word of the datapath
  localparam int WORD_W  = 64;
  localparam int MUL_B_W = 40;
  localparam int DIV_N_W = 80;
  localparam int DIV_D_W = 64;

  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic        [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [DIV_N_W-1:0] div_num_t;
  typedef logic        [DIV_D_W-1:0] div_den_t;

  // register map
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_OSC_OFF   = 3'd1;
  localparam logic [2:0] REG_YIG_OFF   = 3'd2;
  localparam logic [2:0] REG_YIG_LOW   = 3'd3;
  localparam logic [2:0] REG_YIG_HIGH  = 3'd4;
  localparam logic [2:0] REG_REF_LOW   = 3'd5;
  localparam logic [2:0] REG_REF_HIGH  = 3'd6;
  localparam logic [2:0] REG_SPLIT     = 3'd7;

  // status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_ELIG = 2'd1;
  localparam logic [1:0] STATUS_TRUNC   = 2'd2;

  // low band reference window
  localparam logic [27:0] LOW_REF_LOW  = 28'd997000;
  localparam logic [27:0] LOW_REF_HIGH = 28'd999000;

  localparam logic [27:0] FREQ_MAX = 28'hFFFFFFF;

  // margin and score constants
  localparam word_t MARGIN_ONE      = 64'sd65536;
  localparam word_t MARGIN_MIN      = -64'sd131072;
  localparam word_t FRAC_BIAS       = 64'sd131072;
  localparam word_t SCORE_CENTER    = 64'sd2560;
  localparam word_t SCORE_MAX       = 64'sd4194303;
  localparam word_t SCORE_MIN       = -64'sd4194304;
  localparam word_t LOW_SCORE_GAIN  = 64'sd10000;

  // high band score slopes reduced to 32 * distance over a small divisor,
  // divided by reciprocal multiplication with a 40 bit shift
  localparam word_t SCORE_LO_DIV    = 64'sd28125;
  localparam word_t SCORE_HI_DIV    = 64'sd50625;
  localparam word_t SCORE_LO_RECIP  = 64'sd39093746;
  localparam word_t SCORE_HI_RECIP  = 64'sd21718748;
  localparam int    RECIP_SHIFT     = 40;
  localparam int    DIST_SCALE_SH   = 5;

  // configuration register file contents
  typedef struct packed {
    logic               mode;
    logic signed [20:0] osc_off;
    logic signed [20:0] yig_off;
    logic        [27:0] yig_low;
    logic        [27:0] yig_high;
    logic        [27:0] ref_low;
    logic        [27:0] ref_high;
    logic        [27:0] band_split;
  } cfg_t;

endpackage

// ===== hdl/lhps_req_if.sv =====
// ----------------------------------------------------------------------------
// lhps_req_if
// Request channel: one requested oscillator frequency per beat.
// ----------------------------------------------------------------------------
interface lhps_req_if;
  logic        valid;
  logic        ready;
  logic [27:0] osc_freq_khz;

  modport source (output valid, osc_freq_khz, input ready);
  modport sink (input valid, osc_freq_khz, output ready);
endinterface

// ===== hdl/lhps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lhps_rsp_if
// Result channel: one planned candidate per beat.
// ----------------------------------------------------------------------------
interface lhps_rsp_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  candidate_index;
  logic        [7:0]  yig_harmonic;
  logic        [27:0] yig_freq_khz;
  logic        [7:0]  ref_harmonic;
  logic        [27:0] ref_freq_khz;
  logic signed [17:0] tuning_margin;
  logic signed [22:0] tuning_score;
  logic               last;
  logic        [3:0]  preferred_index;
  logic        [1:0]  status;

  modport source (output valid, candidate_index, yig_harmonic, yig_freq_khz,
                  ref_harmonic, ref_freq_khz, tuning_margin, tuning_score,
                  last, preferred_index, status, input ready);
  modport sink (input valid, candidate_index, yig_harmonic, yig_freq_khz,
                ref_harmonic, ref_freq_khz, tuning_margin, tuning_score,
                last, preferred_index, status, output ready);
endinterface

// ===== hdl/lhps_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lhps_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface lhps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [27:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/lhps_cfg.sv =====
// ----------------------------------------------------------------------------
// lhps_cfg
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module lhps_cfg (
  input  logic         clk,
  input  logic         rst,
  lhps_cfg_if.sink     cfg,
  output lhps_pkg::cfg_t regs
);
  import lhps_pkg::*;

  // always able to take a write
  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode       <= 1'b0;
      regs.osc_off    <= 21'sd50000;
      regs.yig_off    <= -21'sd10000;
      regs.yig_low    <= 28'd8000000;
      regs.yig_high   <= 28'd12500000;
      regs.ref_low    <= 28'd1100000;
      regs.ref_high   <= 28'd1260000;
      regs.band_split <= 28'd50000000;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MODE:     regs.mode       <= cfg.data[0];
        REG_OSC_OFF:  regs.osc_off    <= cfg.data[20:0];
        REG_YIG_OFF:  regs.yig_off    <= cfg.data[20:0];
        REG_YIG_LOW:  regs.yig_low    <= cfg.data;
        REG_YIG_HIGH: regs.yig_high   <= cfg.data;
        REG_REF_LOW:  regs.ref_low    <= cfg.data;
        REG_REF_HIGH: regs.ref_high   <= cfg.data;
        REG_SPLIT:    regs.band_split <= cfg.data;
        default: ;
      endcase
    end
  end
endmodule

// ===== hdl/lhps_mul.sv =====
// ----------------------------------------------------------------------------
// lhps_mul
// Shift-add multiplier: signed multiplicand, unsigned multiplier, one bit
// per cycle, stops once the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module lhps_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lhps_pkg::word_t  a,
  input  lhps_pkg::mul_b_t b,
  output logic            busy,
  output logic            done,
  output lhps_pkg::word_t  p
);
  import lhps_pkg::*;

  word_t  acc;
  word_t  ash;
  mul_b_t bsh;
  word_t  acc_next;

  // partial product add
  assign acc_next = bsh[0] ? acc + ash : acc;
  assign p = acc;

  // iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc  <= '0;
        ash  <= a;
        bsh  <= b;
      end else if (busy) begin
        acc <= acc_next;
        ash <= ash <<< 1;
        bsh <= bsh >> 1;
        if (bsh[MUL_B_W-1:1] == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/lhps_div.sv =====
// ----------------------------------------------------------------------------
// lhps_div
// Restoring divider, one quotient bit per cycle, signed dividend over a
// positive divisor, quotient rounded toward minus infinity.
// ----------------------------------------------------------------------------
module lhps_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lhps_pkg::div_num_t num,
  input  lhps_pkg::div_den_t den,
  output logic              busy,
  output logic              done,
  output lhps_pkg::word_t    q
);
  import lhps_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] quo;
  div_den_t           rem;
  div_den_t           dsr;
  logic               neg;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_N_W-1:0] num_mag;
  logic [DIV_D_W:0]   rem_sh;
  logic [DIV_D_W:0]   rem_sub;
  logic               fits;
  logic [DIV_N_W-1:0] q_fix;

  // trial subtract
  assign num_mag = num[DIV_N_W-1] ? DIV_N_W'(-num) : DIV_N_W'(num);
  assign rem_sh  = {rem, quo[DIV_N_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};
  assign fits    = rem_sh >= {1'b0, dsr};

  // floor correction for negative dividends
  assign q_fix = neg ? -(quo + DIV_N_W'(rem != '0)) : quo;
  assign q     = q_fix[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= num[DIV_N_W-1];
        quo  <= num_mag;
        rem  <= '0;
        dsr  <= den;
        cnt  <= CNT_W'(DIV_N_W);
      end else if (busy) begin
        quo <= {quo[DIV_N_W-2:0], fits};
        rem <= fits ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/lo_harmonic_plan_select.sv =====
// ----------------------------------------------------------------------------
// lo_harmonic_plan_select
// Plans YIG and reference harmonics for a requested oscillator frequency.
// ----------------------------------------------------------------------------
// One request is taken at a time; req.ready is high only while the block is
// idle. A request costs up to two range divisions, then for each candidate up
// to eight divisions on the shared divider plus up to ten shift-add
// multiplications that end early on short multipliers. A stalled result
// beat holds the sequencer until it is taken. Each candidate is handed to the
// result register as soon as it is scored; the last beat carries the
// preferred index and status.
`include "assert_macros.svh"

module lo_harmonic_plan_select #(
  parameter int MAX_CANDIDATES = 16
) (
  input  logic        clk,
  input  logic        rst,
  lhps_cfg_if.sink    cfg,
  lhps_req_if.sink    req,
  lhps_rsp_if.source  rsp
);
  import lhps_pkg::*;

  localparam int KW = $clog2(MAX_CANDIDATES);

  typedef enum logic [4:0] {
    S_IDLE, S_DMAX, S_DMIN, S_SETUP, S_NONE,
    S_E, S_DEN, S_NN, S_YH, S_FCHK, S_FDIV, S_YL, S_NZ,
    S_MN, S_RH, S_RL, S_REF, S_YIG, S_LSC, S_SUM, S_DIST,
    S_SCM, S_SCD, S_SCC, S_SEL, S_EMIT
  } state_t;

  cfg_t   regs;
  state_t state;
  state_t ret;
  logic   issued;

  // request working registers
  logic        low;
  logic [27:0] rl, rh, yl, yh;
  word_t       d, mmin, mmax;
  logic        trunc;
  logic [KW-1:0] k, last_k, best;
  logic        have_best;
  word_t       best_val;

  // candidate working registers
  word_t       m, e, den, mn, opnd, fden, r, sc, dist_khz, qs;
  logic [7:0]  n;
  logic [27:0] ref_f, yig_f;

  // result register
  logic               o_valid;
  logic        [3:0]  o_idx;
  logic        [7:0]  o_m;
  logic        [27:0] o_yig;
  logic        [7:0]  o_n;
  logic        [27:0] o_ref;
  logic signed [17:0] o_margin;
  logic signed [22:0] o_score;
  logic               o_last;
  logic        [3:0]  o_pref;
  logic        [1:0]  o_status;

  // shared units
  logic     mul_go, mul_busy, mul_done;
  word_t    mul_a, mul_p;
  mul_b_t   mul_b;
  logic     div_go, div_busy, div_done;
  div_num_t div_num;
  div_den_t div_den;
  word_t    div_q;

  // combinational helpers
  word_t rsum, d_c, total, ftmp, fdiv_val, sc_sat, key;
  word_t sc_div, sc_rem1, sc_ceil;
  logic  elig, out_free, req_fire, req_low, sc_fix, emit_go;
  logic  mid_beat_ok, noelig_beat_ok;

  function automatic word_t min_w(input word_t x, input word_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic [27:0] sat28(input word_t x);
    return (x > word_t'(FREQ_MAX)) ? FREQ_MAX : x[27:0];
  endfunction

  lhps_cfg u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .regs(regs));

  lhps_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .p(mul_p)
  );

  lhps_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .q(div_q)
  );

  // handshakes
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && (state == S_IDLE);
  assign out_free  = !o_valid || rsp.ready;
  assign emit_go   = out_free && ((state == S_NONE) || (state == S_EMIT));

  assign rsp.valid           = o_valid;
  assign rsp.candidate_index = o_idx;
  assign rsp.yig_harmonic    = o_m;
  assign rsp.yig_freq_khz    = o_yig;
  assign rsp.ref_harmonic    = o_n;
  assign rsp.ref_freq_khz    = o_ref;
  assign rsp.tuning_margin   = o_margin;
  assign rsp.tuning_score    = o_score;
  assign rsp.last            = o_last;
  assign rsp.preferred_index = o_pref;
  assign rsp.status          = o_status;

  // derived values
  assign req_low  = req.osc_freq_khz < regs.band_split;
  assign d_c      = word_t'(req.osc_freq_khz) - word_t'(regs.osc_off);
  assign rsum     = word_t'(rl) + word_t'(rh);
  assign total    = (mmax >= mmin) ? mmax - mmin + 64'sd1 : '0;
  assign ftmp     = opnd + (fden <<< 1);
  assign fdiv_val = div_q - FRAC_BIAS;
  assign sc_sat   = (sc > SCORE_MAX) ? SCORE_MAX : ((sc < SCORE_MIN) ? SCORE_MIN : sc);
  assign key      = regs.mode ? sc_sat : r;
  assign elig     = (n != 8'd0) && (low || m[0]);

  // high band score quotient: estimate is exact or one low, fix by remainder
  assign sc_div  = (dist_khz < 0) ? SCORE_LO_DIV : SCORE_HI_DIV;
  assign sc_fix  = opnd >= sc_div;
  assign sc_rem1 = sc_fix ? opnd - sc_div : opnd;
  assign sc_ceil = qs + word_t'(sc_fix) + word_t'(sc_rem1 != '0);

  // result beat checks
  assign mid_beat_ok    = (o_status == STATUS_OK) && (o_pref == 4'd0);
  assign noelig_beat_ok = o_last && (o_pref == 4'd0);

  // operand selection for the shared units
  always_comb begin
    mul_go  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_go  = 1'b0;
    div_num = '0;
    div_den = '0;
    case (state)
      S_DMAX: begin
        div_go  = !issued;
        div_num = div_num_t'(d);
        div_den = div_den_t'(yl);
      end
      S_DMIN: begin
        div_go  = !issued;
        div_num = div_num_t'(d + word_t'(yh) - 64'sd1);
        div_den = div_den_t'(yh);
      end
      S_E: begin
        mul_go = !issued;
        mul_a  = word_t'(regs.yig_off);
        mul_b  = mul_b_t'(m);
      end
      S_DEN: begin
        mul_go = !issued;
        mul_a  = rsum;
        mul_b  = mul_b_t'(m);
      end
      S_NN: begin
        div_go  = !issued;
        div_num = div_num_t'((e <<< 2) + den);
        div_den = div_den_t'(den <<< 1);
      end
      S_YH: begin
        mul_go = !issued;
        mul_a  = word_t'(yh);
        mul_b  = mul_b_t'(m);
      end
      S_FDIV: begin
        div_go  = !issued;
        div_num = div_num_t'({ftmp, 16'h0000});
        div_den = div_den_t'(fden);
      end
      S_YL: begin
        mul_go = !issued;
        mul_a  = word_t'(yl);
        mul_b  = mul_b_t'(m);
      end
      S_MN: begin
        mul_go = !issued;
        mul_a  = m;
        mul_b  = mul_b_t'(n);
      end
      S_RH: begin
        mul_go = !issued;
        mul_a  = word_t'(rh);
        mul_b  = mul_b_t'(mn);
      end
      S_RL: begin
        mul_go = !issued;
        mul_a  = word_t'(rl);
        mul_b  = mul_b_t'(mn);
      end
      S_REF: begin
        div_go  = !issued;
        div_num = div_num_t'((e <<< 1) + mn);
        div_den = div_den_t'(mn <<< 1);
      end
      S_YIG: begin
        div_go  = !issued;
        div_num = div_num_t'((d <<< 1) + m);
        div_den = div_den_t'(m <<< 1);
      end
      S_LSC: begin
        mul_go = !issued;
        mul_a  = r;
        mul_b  = mul_b_t'(LOW_SCORE_GAIN);
      end
      S_SUM: begin
        mul_go = !issued;
        mul_a  = word_t'(yh) + word_t'(yl);
        mul_b  = mul_b_t'(m);
      end
      S_DIST: begin
        div_go  = !issued;
        div_num = div_num_t'(opnd);
        div_den = div_den_t'(m <<< 1);
      end
      S_SCM: begin
        mul_go = !issued;
        mul_a  = opnd;
        mul_b  = (dist_khz < 0) ? mul_b_t'(SCORE_LO_RECIP) : mul_b_t'(SCORE_HI_RECIP);
      end
      S_SCD: begin
        mul_go = !issued;
        mul_a  = qs;
        mul_b  = mul_b_t'(sc_div);
      end
      default: ;
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issued  <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (mul_go || div_go) issued <= 1'b1;
      if (emit_go) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            low <= req_low;
            rl  <= req_low ? LOW_REF_LOW : regs.ref_low;
            rh  <= req_low ? LOW_REF_HIGH : regs.ref_high;
            yl  <= (regs.yig_low == '0) ? 28'd1 : regs.yig_low;
            yh  <= (regs.yig_high == '0) ? 28'd1 : regs.yig_high;
            d   <= d_c;
            if (d_c > 0) begin
              state <= S_DMAX;
            end else begin
              mmin  <= 64'sd1;
              mmax  <= '0;
              state <= S_SETUP;
            end
          end
        end
        S_DMAX: begin
          if (div_done) begin
            issued <= 1'b0;
            mmax   <= div_q;
            state  <= S_DMIN;
          end
        end
        S_DMIN: begin
          if (div_done) begin
            issued <= 1'b0;
            mmin   <= div_q;
            state  <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (total == '0) begin
            state <= S_NONE;
          end else begin
            trunc     <= total > word_t'(MAX_CANDIDATES);
            last_k    <= (total > word_t'(MAX_CANDIDATES)) ? KW'(MAX_CANDIDATES - 1)
                                                           : KW'(total - 64'sd1);
            k         <= '0;
            m         <= mmin;
            have_best <= 1'b0;
            r         <= MARGIN_ONE;
            ref_f     <= '0;
            state     <= S_E;
          end
        end
        S_NONE: begin
          if (out_free) begin
            o_idx    <= '0;
            o_m      <= '0;
            o_yig    <= '0;
            o_n      <= '0;
            o_ref    <= '0;
            o_margin <= '0;
            o_score  <= '0;
            o_last   <= 1'b1;
            o_pref   <= '0;
            o_status <= STATUS_NO_ELIG;
            state    <= S_IDLE;
          end
        end
        S_E: begin
          if (mul_done) begin
            issued <= 1'b0;
            e      <= d - mul_p;
            state  <= S_DEN;
          end
        end
        S_DEN: begin
          if (mul_done) begin
            issued <= 1'b0;
            den    <= mul_p;
            if (e > 0 && rsum > 0) begin
              state <= S_NN;
            end else begin
              n     <= '0;
              state <= S_YH;
            end
          end
        end
        S_NN: begin
          if (div_done) begin
            issued <= 1'b0;
            n      <= (div_q >= 64'sd1 && div_q <= 64'sd255) ? div_q[7:0] : 8'd0;
            state  <= S_YH;
          end
        end
        S_YH: begin
          if (mul_done) begin
            issued <= 1'b0;
            opnd   <= mul_p - d;
            fden   <= d;
            ret    <= S_YL;
            state  <= S_FCHK;
          end
        end
        // fraction: saturate the easy cases, else divide
        S_FCHK: begin
          if (opnd >= fden) begin
            r     <= min_w(r, MARGIN_ONE);
            state <= ret;
          end else if (opnd <= -(fden <<< 1)) begin
            r     <= min_w(r, MARGIN_MIN);
            state <= ret;
          end else begin
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (div_done) begin
            issued <= 1'b0;
            r      <= min_w(r, fdiv_val);
            state  <= ret;
          end
        end
        S_YL: begin
          if (mul_done) begin
            issued <= 1'b0;
            opnd   <= d - mul_p;
            fden   <= d;
            ret    <= (n != 8'd0) ? S_MN : S_NZ;
            state  <= S_FCHK;
          end
        end
        S_NZ: begin
          r     <= MARGIN_MIN;
          state <= S_YIG;
        end
        S_MN: begin
          if (mul_done) begin
            issued <= 1'b0;
            mn     <= mul_p;
            state  <= S_RH;
          end
        end
        S_RH: begin
          if (mul_done) begin
            issued <= 1'b0;
            opnd   <= mul_p - e;
            fden   <= e;
            ret    <= S_RL;
            state  <= S_FCHK;
          end
        end
        S_RL: begin
          if (mul_done) begin
            issued <= 1'b0;
            opnd   <= e - mul_p;
            fden   <= e;
            ret    <= S_REF;
            state  <= S_FCHK;
          end
        end
        S_REF: begin
          if (div_done) begin
            issued <= 1'b0;
            ref_f  <= sat28(div_q);
            state  <= S_YIG;
          end
        end
        S_YIG: begin
          if (div_done) begin
            issued <= 1'b0;
            yig_f  <= sat28(div_q);
            if (low) begin
              state <= S_LSC;
            end else if (r < 64'sd1) begin
              sc    <= '0;
              state <= S_SEL;
            end else begin
              state <= S_SUM;
            end
          end
        end
        S_LSC: begin
          if (mul_done) begin
            issued <= 1'b0;
            sc     <= mul_p >>> 8;
            state  <= S_SEL;
          end
        end
        S_SUM: begin
          if (mul_done) begin
            issued <= 1'b0;
            opnd   <= (d <<< 1) - mul_p;
            state  <= S_DIST;
          end
        end
        // distance from band center, then 32 times its magnitude
        S_DIST: begin
          if (div_done) begin
            issued   <= 1'b0;
            dist_khz <= div_q;
            opnd     <= ((div_q < 0) ? -div_q : div_q) <<< DIST_SCALE_SH;
            state    <= S_SCM;
          end
        end
        // quotient estimate by reciprocal
        S_SCM: begin
          if (mul_done) begin
            issued <= 1'b0;
            qs     <= mul_p >>> RECIP_SHIFT;
            state  <= S_SCD;
          end
        end
        // remainder of the estimate
        S_SCD: begin
          if (mul_done) begin
            issued <= 1'b0;
            opnd   <= opnd - mul_p;
            state  <= S_SCC;
          end
        end
        // score falls off by the rounded-up quotient on both sides
        S_SCC: begin
          sc    <= SCORE_CENTER - sc_ceil;
          state <= S_SEL;
        end
        // running choice of the preferred candidate
        S_SEL: begin
          sc <= sc_sat;
          if (elig && (!have_best || key > best_val)) begin
            have_best <= 1'b1;
            best      <= k;
            best_val  <= key;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            o_idx    <= 4'(k);
            o_m      <= (m > 64'sd255) ? 8'd255 : m[7:0];
            o_yig    <= yig_f;
            o_n      <= n;
            o_ref    <= ref_f;
            o_margin <= r[17:0];
            o_score  <= sc[22:0];
            if (k == last_k) begin
              o_last   <= 1'b1;
              o_pref   <= have_best ? 4'(best) : 4'd0;
              o_status <= !have_best ? STATUS_NO_ELIG : (trunc ? STATUS_TRUNC : STATUS_OK);
              state    <= S_IDLE;
            end else begin
              o_last   <= 1'b0;
              o_pref   <= '0;
              o_status <= STATUS_OK;
              k        <= k + 1'b1;
              m        <= m + 64'sd1;
              r        <= MARGIN_ONE;
              ref_f    <= '0;
              state    <= S_E;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_NEVER(a_unit_overlap, mul_go && div_go, "multiplier and divider started together")
  `ASSERT_IMPLIES(a_mul_free, mul_go || div_go, !mul_busy && !div_busy, "unit started while busy")
  `ASSERT_IMPLIES(a_mid_beat, rsp.valid && !rsp.last, mid_beat_ok, "summary on a middle beat")
  `ASSERT_IMPLIES(a_noelig_pref, rsp.valid && rsp.status == STATUS_NO_ELIG, noelig_beat_ok,
                  "bad no-eligible beat")

endmodule
